[sv/ookpwr_pkg.sv]
// Shared constants for the on-off-keyed pulse width receiver.
// Holds register indexes, reset values, result status codes and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ookpwr_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_SYNC_GAP_MIN = 3'd0;
	localparam logic [2:0] REG_SYNC_MARGIN  = 3'd1;
	localparam logic [2:0] REG_GLITCH_MAX   = 3'd2;
	localparam logic [2:0] REG_PULSE_MIN    = 3'd3;
	localparam logic [2:0] REG_BIT_SPLIT    = 3'd4;
	localparam logic [2:0] REG_END_GAP_MAX  = 3'd5;

	// Register reset values.
	localparam logic [15:0] RST_SYNC_GAP_MIN = 16'd2750;
	localparam logic [9:0]  RST_SYNC_MARGIN  = 10'd100;
	localparam logic [9:0]  RST_GLITCH_MAX   = 10'd50;
	localparam logic [9:0]  RST_PULSE_MIN    = 10'd100;
	localparam logic [15:0] RST_BIT_SPLIT    = 16'd700;
	localparam logic [15:0] RST_END_GAP_MAX  = 16'd30000;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_END_LONG  = 2'd1;
	localparam logic [1:0] STATUS_BITS_ODD  = 2'd2;
	localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

	// A frame needs more than this many edges to be accepted.
	localparam int unsigned MIN_FRAME_EDGES = 6;

	// Field widths.
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CODE_W   = 64;
	localparam int unsigned BCNT_W   = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OUT_W    = STATUS_W + CODE_W + BCNT_W + TIME_W;

	typedef logic [TIME_W-1:0] time_t;

endpackage

`default_nettype wire

[sv/ook_pulse_width_receiver.sv]
// On-off-keyed pulse width receiver: captures edge-to-edge durations and
// decodes a frame of high/low pairs when a second sync gap closes it.
// Depends on ookpwr_pkg.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | s_axis_tvalid/tready, tdata[31:0]        | in
//  result   | m_axis_tvalid/tready, tdata[103:0]       | out
//  config   | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//
// An edge without a result is accepted and then evaluated. An edge that closes
// a frame with bits to decode walks the duration memory through its single
// read port, one entry a cycle, and then drains the read register. A rejected
// frame goes from evaluation straight to the result stage.
// Reset brings the configuration and control registers to their defaults;
// datapath and store have no reset; entry 0 is never read, dur0_q keeps it.
// A waiting result does not block the next edge; a new result waits for it.
`timescale 1ns / 1ps
`default_nettype none

module ook_pulse_width_receiver #(
	parameter int unsigned MAX_EDGES = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// edge_time[31:0]
	input  wire logic [31:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[1:0], code[65:2], bit_count[71:66], sync_duration[103:72]
	output logic [103:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned EW = $clog2(MAX_EDGES + 1);
	localparam int unsigned TW = ookpwr_pkg::TIME_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EVAL   = 2'd1;
	localparam logic [1:0] S_DECODE = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	// Configuration registers.
	logic [15:0] sync_gap_min_q;
	logic [9:0]  sync_margin_q;
	logic [9:0]  glitch_max_q;
	logic [9:0]  pulse_min_q;
	logic [15:0] bit_split_q;
	logic [15:0] end_gap_max_q;

	logic [1:0]              state_q;
	ookpwr_pkg::time_t       last_time_q;
	ookpwr_pkg::time_t       dur_q;
	ookpwr_pkg::time_t       dur0_q;
	ookpwr_pkg::time_t       sync_dur_q;
	logic [EW-1:0]           ec_q;
	logic [1:0]              sr_q;
	logic [EW-1:0]           n_q;
	logic [EW-1:0]           iss_q;
	logic [1:0]              status_q;
	logic [63:0]             code_q;
	logic                    abort_q;
	logic                    hi_short_q;
	logic                    m_valid_q;
	logic [103:0]            out_data_q;

	logic [TW-1:0]           mem [MAX_EDGES];
	logic [TW-1:0]           rd_data_s1;
	logic                    rd_vld_s1;
	logic                    rd_odd_s1;

	// Evaluation of one edge.
	logic                    accept;
	logic                    gap_over;
	logic                    repeat_hit;
	logic                    full;
	logic                    glitch;
	logic                    restart;
	logic [1:0]              sr_inc;
	logic                    fire;
	logic                    end_long;
	ookpwr_pkg::time_t       threshold;
	logic [EW-1:0]           ec_base;
	logic [EW-1:0]           n_new;
	logic [EW-1:0]           pair_end;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic                    rd_en;
	logic [EW-1:0]           iss_next;
	logic [AW-1:0]           rd_addr;
	logic                    lo_short;
	logic                    hi_short;
	logic                    lo_big;
	logic [EW+5:0]           bits_wide;
	logic                    out_free;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign gap_over   = (dur_q[31:16] != 16'd0) || (dur_q[15:0] > sync_gap_min_q);
	assign threshold  = dur0_q - {22'd0, sync_margin_q};
	assign repeat_hit = dur_q > threshold;
	assign full       = ec_q >= EW'(MAX_EDGES);
	assign glitch     = (dur_q[31:10] == 22'd0) && (dur_q[9:0] < glitch_max_q);
	assign restart    = gap_over || full || glitch;
	assign sr_inc     = sr_q + 2'd1;
	assign fire       = gap_over && repeat_hit && (sr_inc == 2'd2);
	assign end_long   = (dur_q[31:16] != 16'd0) || (dur_q[15:0] > end_gap_max_q);
	assign ec_base    = restart ? '0 : ec_q;
	assign n_new      = (ec_q == '0) ? '0 : ec_q - 1'b1;

	// Every edge is stored: after a restart at entry 0, otherwise the store
	// still has room because a full store always restarts.
	assign wr_en   = (state_q == S_EVAL);
	assign wr_addr = ec_base[AW-1:0];

	assign pair_end = {n_q[EW-1:1], 1'b0};
	assign rd_en    = (state_q == S_DECODE) && (iss_q < pair_end);
	assign iss_next = iss_q + 1'b1;
	assign rd_addr  = iss_next[AW-1:0];

	assign hi_short = (rd_data_s1[31:10] == 22'd0) && (rd_data_s1[9:0] < pulse_min_q);
	assign lo_short = hi_short;
	assign lo_big   = (rd_data_s1[31:16] != 16'd0) || (rd_data_s1[15:0] > bit_split_q);
	assign bits_wide = {6'd0, n_q} >> 1;
	assign out_free  = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_gap_min_q <= ookpwr_pkg::RST_SYNC_GAP_MIN;
			sync_margin_q  <= ookpwr_pkg::RST_SYNC_MARGIN;
			glitch_max_q   <= ookpwr_pkg::RST_GLITCH_MAX;
			pulse_min_q    <= ookpwr_pkg::RST_PULSE_MIN;
			bit_split_q    <= ookpwr_pkg::RST_BIT_SPLIT;
			end_gap_max_q  <= ookpwr_pkg::RST_END_GAP_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ookpwr_pkg::REG_SYNC_GAP_MIN: sync_gap_min_q <= cfg_data;
				ookpwr_pkg::REG_SYNC_MARGIN:  sync_margin_q  <= cfg_data[9:0];
				ookpwr_pkg::REG_GLITCH_MAX:   glitch_max_q   <= cfg_data[9:0];
				ookpwr_pkg::REG_PULSE_MIN:    pulse_min_q    <= cfg_data[9:0];
				ookpwr_pkg::REG_BIT_SPLIT:    bit_split_q    <= cfg_data;
				ookpwr_pkg::REG_END_GAP_MAX:  end_gap_max_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Duration store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= dur_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_time_q <= '0;
			dur0_q      <= '0;
			ec_q        <= '0;
			sr_q        <= '0;
			rd_vld_s1   <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_time_q <= s_axis_tdata;
						state_q     <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (gap_over) begin
						if (repeat_hit) begin
							sr_q <= fire ? 2'd0 : sr_inc;
						end
					end else if (full || glitch) begin
						sr_q <= 2'd0;
					end
					ec_q <= ec_base + 1'b1;
					if (ec_base == '0) begin
						dur0_q <= dur_q;
					end
					if (!fire) begin
						state_q <= S_IDLE;
					end else if (!end_long && (n_new[3:1] == 3'd0)
						&& (32'(n_new) > 32'(ookpwr_pkg::MIN_FRAME_EDGES))) begin
						// Bit count is a multiple of 8 and the frame is long enough.
						state_q <= S_DECODE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DECODE: begin
					if (!rd_en && !rd_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q <= s_axis_tdata - last_time_q;
		end
		if (state_q == S_EVAL && fire) begin
			n_q        <= n_new;
			iss_q      <= '0;
			sync_dur_q <= dur0_q;
			code_q     <= '0;
			abort_q    <= 1'b0;
			if (end_long) begin
				status_q <= ookpwr_pkg::STATUS_END_LONG;
			end else if (n_new[3:1] != 3'd0) begin
				status_q <= ookpwr_pkg::STATUS_BITS_ODD;
			end else if (32'(n_new) > 32'(ookpwr_pkg::MIN_FRAME_EDGES)) begin
				status_q <= ookpwr_pkg::STATUS_OK;
			end else begin
				status_q <= ookpwr_pkg::STATUS_TOO_SHORT;
			end
		end
		if (rd_en) begin
			iss_q     <= iss_next;
			rd_odd_s1 <= rd_addr[0];
		end
		// Odd entries are high parts, even entries the low parts that follow.
		if (rd_vld_s1) begin
			if (rd_odd_s1) begin
				hi_short_q <= hi_short;
			end else if (!abort_q) begin
				if (hi_short_q || lo_short) begin
					code_q  <= '0;
					abort_q <= 1'b1;
				end else begin
					code_q <= {code_q[62:0], !lo_big};
				end
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_data_q <= {sync_dur_q, bits_wide[5:0], code_q, status_q};
		end
	end

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EVAL)
		else $error("accepted edge not evaluated next cycle");

	a_no_write_decode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECODE |-> !wr_en)
		else $error("store written during decode");

	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		sr_q == 2'd0 || sr_q == 2'd1)
		else $error("sync repeat count out of range");

	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == S_DECODE)
		else $error("store read outside decode");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> ec_q <= EW'(MAX_EDGES) && ec_q != '0)
		else $error("edge count out of range after evaluation");

endmodule

`default_nettype wire
